/* src/stop_and_wait_frame_receiver_unit_assert.svh */
// Assertion macros shared by the frame receiver modules.
`ifndef STOP_AND_WAIT_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define STOP_AND_WAIT_FRAME_RECEIVER_UNIT_ASSERT_SVH

// Same-cycle implication, switched off while reset is high.
`define SWFR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swfr check failed");

// Next-cycle implication, switched off while reset is high.
`define SWFR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swfr check failed");

`endif

/* src/swfr_pkg.sv */
// Types, codes and constants of the stop-and-wait frame receiver.
package swfr_pkg;

  // Default payload limit of one frame
  localparam int MAX_PAYLOAD_DEF = 1024;

  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 11;
  localparam int VERDICT_W = 2;
  localparam int REPLY_W  = 3;

  // APB register map
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_FLAG     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ADDRESS  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CTRL0    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CTRL1    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ESCAPE   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ESC_FLAG = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_ESC_ESC  = 3'd6;

  // Register reset values
  localparam logic [BYTE_W-1:0] FLAG_RST     = 8'd126;
  localparam logic [BYTE_W-1:0] ADDRESS_RST  = 8'd3;
  localparam logic [BYTE_W-1:0] CTRL0_RST    = 8'd0;
  localparam logic [BYTE_W-1:0] CTRL1_RST    = 8'd64;
  localparam logic [BYTE_W-1:0] ESCAPE_RST   = 8'd125;
  localparam logic [BYTE_W-1:0] ESC_FLAG_RST = 8'd94;
  localparam logic [BYTE_W-1:0] ESC_ESC_RST  = 8'd93;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REPORT  = 1'b1;

  // Verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_ACCEPTED = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_DUPLICATE = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_REJECTED = 2'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_BAD_ESC  = 2'd3;

  // Reply codes
  localparam logic [REPLY_W-1:0] REPLY_RR0  = 3'd0;
  localparam logic [REPLY_W-1:0] REPLY_RR1  = 3'd1;
  localparam logic [REPLY_W-1:0] REPLY_REJ0 = 3'd2;
  localparam logic [REPLY_W-1:0] REPLY_REJ1 = 3'd3;
  localparam logic [REPLY_W-1:0] REPLY_NONE = 3'd4;

  // Frame hunt states
  typedef enum logic [2:0] {
    ST_HUNT = 3'd0,
    ST_FLAG = 3'd1,
    ST_ADDR = 3'd2,
    ST_CTRL = 3'd3,
    ST_DATA = 3'd4,
    ST_ESC  = 3'd5
  } state_t;

  // Configuration seen by the deframer
  typedef struct packed {
    logic [BYTE_W-1:0] flag_byte;
    logic [BYTE_W-1:0] address_byte;
    logic [BYTE_W-1:0] control_seq_zero;
    logic [BYTE_W-1:0] control_seq_one;
    logic [BYTE_W-1:0] escape_byte;
    logic [BYTE_W-1:0] escaped_flag_code;
    logic [BYTE_W-1:0] escaped_escape_code;
  } cfg_t;

  // One result beat
  typedef struct packed {
    logic                 kind;
    logic [BYTE_W-1:0]    payload_byte;
    logic [LEN_W-1:0]     frame_length;
    logic [VERDICT_W-1:0] verdict;
    logic [REPLY_W-1:0]   reply;
  } res_t;

  // Handshake between deframer and result register
  typedef struct packed {
    logic load;
    logic slot_free;
  } out_ctl_t;

endpackage

/* src/stop_and_wait_frame_receiver_unit.sv */
// Top level of the byte-stuffed stop-and-wait frame receiver.
//
//  channel  | dir | beat fields
//  ---------+-----+--------------------------------------------------------
//  s_*      | in  | tdata: rx_byte
//  m_*      | out | tuser: kind; tdata: payload_byte, frame_length, verdict,
//           |     |        reply
//  APB      | in  | seven 8-bit framing registers at byte address 4*i
//
// One received byte per cycle unless the m side stalls: input register, one
// pass of compare and destuff logic, result register. Reset is synchronous
// and returns the registers to their defaults and the receiver to flag
// hunting. A stalled m side fills the result register and then the input
// register before s_tready drops.
module stop_and_wait_frame_receiver_unit #(
  parameter int MAX_PAYLOAD = swfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // receive byte stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] rx_byte
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [23:0]                     m_tdata,   // [7:0] payload_byte,
                                                     // [18:8] frame_length,
                                                     // [20:19] verdict,
                                                     // [23:21] reply
  output logic                            m_tuser,   // [0] kind
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [swfr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [swfr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [swfr_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  swfr_pkg::cfg_t     cfg;
  swfr_pkg::out_ctl_t out_ctl;
  swfr_pkg::res_t     res_core;
  swfr_pkg::res_t     res_q;
  logic               slot_free;

  swfr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  swfr_deframer #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_deframer (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .cfg       (cfg),
    .slot_free (slot_free),
    .out_ctl   (out_ctl),
    .res       (res_core)
  );

  swfr_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .out_ctl   (out_ctl),
    .res_in    (res_core),
    .slot_free (slot_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .res_out   (res_q)
  );

  // pack the result beat
  assign m_tdata = {res_q.reply, res_q.verdict, res_q.frame_length, res_q.payload_byte};
  assign m_tuser = res_q.kind;

endmodule

/* src/swfr_cfg_regs.sv */
// APB register file holding the framing bytes.
module swfr_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swfr_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [swfr_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [swfr_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output swfr_pkg::cfg_t                      cfg
);

  logic [swfr_pkg::REG_IDX_W-1:0] idx;
  logic                           wr_en;
  logic [swfr_pkg::BYTE_W-1:0]    wbyte;
  logic [swfr_pkg::BYTE_W-1:0]    rbyte;

  // word address; the low byte-lane bits select nothing
  assign idx    = paddr[swfr_pkg::APB_ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign wbyte  = pwdata[swfr_pkg::BYTE_W-1:0];
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flag_byte           <= swfr_pkg::FLAG_RST;
      cfg.address_byte        <= swfr_pkg::ADDRESS_RST;
      cfg.control_seq_zero    <= swfr_pkg::CTRL0_RST;
      cfg.control_seq_one     <= swfr_pkg::CTRL1_RST;
      cfg.escape_byte         <= swfr_pkg::ESCAPE_RST;
      cfg.escaped_flag_code   <= swfr_pkg::ESC_FLAG_RST;
      cfg.escaped_escape_code <= swfr_pkg::ESC_ESC_RST;
    end else if (wr_en) begin
      unique case (idx)
        swfr_pkg::REG_FLAG:     cfg.flag_byte           <= wbyte;
        swfr_pkg::REG_ADDRESS:  cfg.address_byte        <= wbyte;
        swfr_pkg::REG_CTRL0:    cfg.control_seq_zero    <= wbyte;
        swfr_pkg::REG_CTRL1:    cfg.control_seq_one     <= wbyte;
        swfr_pkg::REG_ESCAPE:   cfg.escape_byte         <= wbyte;
        swfr_pkg::REG_ESC_FLAG: cfg.escaped_flag_code   <= wbyte;
        swfr_pkg::REG_ESC_ESC:  cfg.escaped_escape_code <= wbyte;
        default: ;
      endcase
    end
  end

  // read mux; unmapped words read zero
  always_comb begin
    unique case (idx)
      swfr_pkg::REG_FLAG:     rbyte = cfg.flag_byte;
      swfr_pkg::REG_ADDRESS:  rbyte = cfg.address_byte;
      swfr_pkg::REG_CTRL0:    rbyte = cfg.control_seq_zero;
      swfr_pkg::REG_CTRL1:    rbyte = cfg.control_seq_one;
      swfr_pkg::REG_ESCAPE:   rbyte = cfg.escape_byte;
      swfr_pkg::REG_ESC_FLAG: rbyte = cfg.escaped_flag_code;
      swfr_pkg::REG_ESC_ESC:  rbyte = cfg.escaped_escape_code;
      default:                rbyte = '0;
    endcase
  end

  assign prdata = {{(swfr_pkg::APB_DATA_W-swfr_pkg::BYTE_W){1'b0}}, rbyte};

endmodule

/* src/swfr_deframer.sv */
// Input register, hunt state machine and destuffing datapath.
`include "stop_and_wait_frame_receiver_unit_assert.svh"
module swfr_deframer #(
  parameter int MAX_PAYLOAD = swfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [swfr_pkg::BYTE_W-1:0]  in_byte,
  input  swfr_pkg::cfg_t               cfg,
  input  logic                         slot_free,
  output swfr_pkg::out_ctl_t           out_ctl,
  output swfr_pkg::res_t               res
);

  localparam int CW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PAYLOAD);

  // input register
  logic                        ibuf_valid;
  logic [swfr_pkg::BYTE_W-1:0] ibuf_byte;
  logic                        advance;

  // frame state
  swfr_pkg::state_t            state, state_next;
  logic                        frame_seq, frame_seq_next;
  logic                        expected_seq, expected_seq_next;
  logic                        held_valid, held_valid_next;
  logic [swfr_pkg::BYTE_W-1:0] held_byte, held_byte_next;
  logic [swfr_pkg::BYTE_W-1:0] running_xor, running_xor_next;
  logic [CW-1:0]               byte_count, byte_count_next;

  // decode
  logic                        b_flag, b_esc, b_addr, b_c0, b_c1, b_hdr;
  logic                        code_flag, code_esc;
  logic                        take, overflow, good_check;
  logic [swfr_pkg::BYTE_W-1:0] take_byte;
  logic [CW+swfr_pkg::LEN_W-1:0] cnt_ext;
  logic [swfr_pkg::LEN_W-1:0]  frame_len;
  logic                        emit;

  assign advance  = ibuf_valid && slot_free;
  assign in_ready = !ibuf_valid || slot_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ibuf_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      ibuf_valid <= 1'b1;
    end else if (advance) begin
      ibuf_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ibuf_byte <= in_byte;
    end
  end

  // byte compares against the framing registers
  assign b_flag    = ibuf_byte == cfg.flag_byte;
  assign b_esc     = ibuf_byte == cfg.escape_byte;
  assign b_addr    = ibuf_byte == cfg.address_byte;
  assign b_c0      = ibuf_byte == cfg.control_seq_zero;
  assign b_c1      = ibuf_byte == cfg.control_seq_one;
  assign b_hdr     = ibuf_byte == (cfg.address_byte ^
                     (frame_seq ? cfg.control_seq_one : cfg.control_seq_zero));
  assign code_flag = ibuf_byte == cfg.escaped_flag_code;
  assign code_esc  = ibuf_byte == cfg.escaped_escape_code;

  // a destuffed data byte enters the hold stage
  assign take = ((state == swfr_pkg::ST_DATA) && !b_flag && !b_esc) ||
                ((state == swfr_pkg::ST_ESC) && (code_flag || code_esc));
  assign take_byte = (state == swfr_pkg::ST_DATA) ? ibuf_byte :
                     (code_flag ? cfg.flag_byte : cfg.escape_byte);
  assign overflow   = held_valid && (byte_count >= CNT_MAX);
  assign good_check = held_valid && (running_xor == '0);

  assign cnt_ext   = {{swfr_pkg::LEN_W{1'b0}}, byte_count};
  assign frame_len = cnt_ext[swfr_pkg::LEN_W-1:0];

  // next hunt state
  always_comb begin
    state_next = state;
    unique case (state)
      swfr_pkg::ST_FLAG: begin
        if (b_addr)      state_next = swfr_pkg::ST_ADDR;
        else if (b_flag) state_next = swfr_pkg::ST_FLAG;
        else             state_next = swfr_pkg::ST_HUNT;
      end
      swfr_pkg::ST_ADDR: begin
        if (b_c0 || b_c1) state_next = swfr_pkg::ST_CTRL;
        else if (b_flag)  state_next = swfr_pkg::ST_FLAG;
        else              state_next = swfr_pkg::ST_HUNT;
      end
      swfr_pkg::ST_CTRL: begin
        state_next = b_hdr ? swfr_pkg::ST_DATA : swfr_pkg::ST_HUNT;
      end
      swfr_pkg::ST_DATA: begin
        if (b_flag)                state_next = swfr_pkg::ST_HUNT;
        else if (b_esc)            state_next = swfr_pkg::ST_ESC;
        else if (overflow)         state_next = swfr_pkg::ST_HUNT;
        else                       state_next = swfr_pkg::ST_DATA;
      end
      swfr_pkg::ST_ESC: begin
        state_next = (take && !overflow) ? swfr_pkg::ST_DATA : swfr_pkg::ST_HUNT;
      end
      default: begin
        state_next = b_flag ? swfr_pkg::ST_FLAG : swfr_pkg::ST_HUNT;
      end
    endcase
  end

  // result and datapath next values
  always_comb begin
    emit              = 1'b0;
    res.kind          = swfr_pkg::KIND_PAYLOAD;
    res.payload_byte  = '0;
    res.frame_length  = '0;
    res.verdict       = swfr_pkg::VERDICT_ACCEPTED;
    res.reply         = swfr_pkg::REPLY_NONE;
    frame_seq_next    = frame_seq;
    expected_seq_next = expected_seq;
    held_valid_next   = held_valid;
    held_byte_next    = held_byte;
    running_xor_next  = running_xor;
    byte_count_next   = byte_count;

    unique case (state)
      swfr_pkg::ST_ADDR: begin
        if (b_c0)      frame_seq_next = 1'b0;
        else if (b_c1) frame_seq_next = 1'b1;
      end
      swfr_pkg::ST_CTRL: begin
        if (b_hdr) begin
          held_valid_next  = 1'b0;
          held_byte_next   = '0;
          running_xor_next = '0;
          byte_count_next  = '0;
        end
      end
      swfr_pkg::ST_DATA, swfr_pkg::ST_ESC: begin
        if ((state == swfr_pkg::ST_DATA) && b_flag) begin
          // closing flag: frame report
          emit             = 1'b1;
          res.kind         = swfr_pkg::KIND_REPORT;
          res.frame_length = frame_len;
          if (good_check) begin
            res.reply = frame_seq ? swfr_pkg::REPLY_RR0 : swfr_pkg::REPLY_RR1;
            if (frame_seq == expected_seq) begin
              res.verdict = swfr_pkg::VERDICT_ACCEPTED;
              if (byte_count != '0) expected_seq_next = ~expected_seq;
            end else begin
              res.verdict = swfr_pkg::VERDICT_DUPLICATE;
            end
          end else if (frame_seq != expected_seq) begin
            res.verdict = swfr_pkg::VERDICT_DUPLICATE;
            res.reply   = expected_seq ? swfr_pkg::REPLY_RR1 : swfr_pkg::REPLY_RR0;
          end else begin
            res.verdict = swfr_pkg::VERDICT_REJECTED;
            res.reply   = frame_seq ? swfr_pkg::REPLY_REJ1 : swfr_pkg::REPLY_REJ0;
          end
        end else if (take) begin
          if (overflow) begin
            // over-long frame ends here
            emit             = 1'b1;
            res.kind         = swfr_pkg::KIND_REPORT;
            res.frame_length = frame_len;
            res.verdict      = swfr_pkg::VERDICT_REJECTED;
            res.reply        = frame_seq ? swfr_pkg::REPLY_REJ1 : swfr_pkg::REPLY_REJ0;
          end else begin
            if (held_valid) begin
              emit             = 1'b1;
              res.payload_byte = held_byte;
              byte_count_next  = byte_count + CW'(1);
            end
            held_byte_next   = take_byte;
            held_valid_next  = 1'b1;
            running_xor_next = running_xor ^ take_byte;
          end
        end else if (state == swfr_pkg::ST_ESC) begin
          // unknown escape code
          emit             = 1'b1;
          res.kind         = swfr_pkg::KIND_REPORT;
          res.frame_length = frame_len;
          res.verdict      = swfr_pkg::VERDICT_BAD_ESC;
          res.reply        = swfr_pkg::REPLY_NONE;
        end
      end
      default: ;
    endcase
  end

  assign out_ctl.load      = advance && emit;
  assign out_ctl.slot_free = slot_free;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= swfr_pkg::ST_HUNT;
      frame_seq    <= 1'b0;
      expected_seq <= 1'b0;
      held_valid   <= 1'b0;
      held_byte    <= '0;
      running_xor  <= '0;
      byte_count   <= '0;
    end else if (advance) begin
      state        <= state_next;
      frame_seq    <= frame_seq_next;
      expected_seq <= expected_seq_next;
      held_valid   <= held_valid_next;
      held_byte    <= held_byte_next;
      running_xor  <= running_xor_next;
      byte_count   <= byte_count_next;
    end
  end

  `SWFR_ASSERT_NOW(a_count_limit, clk, rst, 1'b1, byte_count <= CNT_MAX)
  `SWFR_ASSERT_NOW(a_count_needs_hold, clk, rst, byte_count != '0, held_valid)
  `SWFR_ASSERT_NOW(a_report_rehunts, clk, rst,
    out_ctl.load && (res.kind == swfr_pkg::KIND_REPORT), state_next == swfr_pkg::ST_HUNT)
  `SWFR_ASSERT_NEXT(a_seq_only_on_report, clk, rst,
    !(out_ctl.load && (res.kind == swfr_pkg::KIND_REPORT)), $stable(expected_seq))

endmodule

/* src/swfr_out_reg.sv */
// Result register on the master side of the stream.
`include "stop_and_wait_frame_receiver_unit_assert.svh"
module swfr_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  swfr_pkg::out_ctl_t out_ctl,
  input  swfr_pkg::res_t     res_in,
  output logic               slot_free,
  output logic               m_tvalid,
  input  logic               m_tready,
  output swfr_pkg::res_t     res_out
);

  assign slot_free = !m_tvalid || m_tready;

  // valid flag: load wins over drain
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ctl.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ctl.load) begin
      res_out <= res_in;
    end
  end

  `SWFR_ASSERT_NOW(a_no_overwrite, clk, rst, out_ctl.load, !m_tvalid || m_tready)
  `SWFR_ASSERT_NOW(a_load_when_free, clk, rst, out_ctl.load, out_ctl.slot_free)

endmodule

/* verif/swfr_result_checker.sv */
`timescale 1ns / 1ps
// Result checker: follows the deframer on every byte beat and checks each result beat.
module swfr_result_checker #(
  parameter int MAX_PAYLOAD = swfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [7:0]                      s_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [23:0]                     m_tdata,
  input  logic                            m_tuser,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [swfr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [swfr_pkg::APB_DATA_W-1:0] pwdata,
  input  logic                            pready,
  output int                              errors,
  output int                              pending,
  output int                              n_payload,
  output int                              n_report
);

  // Framing registers as the block should see them
  swfr_pkg::cfg_t   cfg;
  // Deframer state
  swfr_pkg::state_t hunt;
  logic             frame_seq;
  logic             expected_seq;
  logic             held_valid;
  logic [7:0]       held_byte;
  logic [7:0]       running_xor;
  int               byte_count;
  // Results still owed by the block, oldest first
  swfr_pkg::res_t   due_results[$];

  function automatic logic [swfr_pkg::REPLY_W-1:0] rr_of(input logic seq);
    return seq ? swfr_pkg::REPLY_RR1 : swfr_pkg::REPLY_RR0;
  endfunction

  function automatic logic [swfr_pkg::REPLY_W-1:0] rej_of(input logic seq);
    return seq ? swfr_pkg::REPLY_REJ1 : swfr_pkg::REPLY_REJ0;
  endfunction

  // End-of-frame report; the receiver always goes back to hunting afterwards
  task automatic push_report(input logic [swfr_pkg::VERDICT_W-1:0] verdict,
                             input logic [swfr_pkg::REPLY_W-1:0] reply);
    swfr_pkg::res_t r;
    r.kind         = swfr_pkg::KIND_REPORT;
    r.payload_byte = '0;
    r.frame_length = swfr_pkg::LEN_W'(byte_count);
    r.verdict      = verdict;
    r.reply        = reply;
    due_results.push_back(r);
    hunt = swfr_pkg::ST_HUNT;
  endtask

  // A destuffed byte releases the one held back before it
  task automatic take_data(input logic [7:0] d);
    swfr_pkg::res_t r;
    if (held_valid) begin
      if (byte_count >= MAX_PAYLOAD) begin
        // over-long frame ends here
        push_report(swfr_pkg::VERDICT_REJECTED, rej_of(frame_seq));
        return;
      end
      r.kind         = swfr_pkg::KIND_PAYLOAD;
      r.payload_byte = held_byte;
      r.frame_length = '0;
      r.verdict      = swfr_pkg::VERDICT_ACCEPTED;
      r.reply        = swfr_pkg::REPLY_NONE;
      due_results.push_back(r);
      byte_count++;
    end
    held_byte   = d;
    held_valid  = 1'b1;
    running_xor = running_xor ^ d;
  endtask

  // Closing flag: verdict from data check and sequence numbers
  task automatic close_frame();
    if (held_valid && running_xor == 8'h00) begin
      if (frame_seq == expected_seq) begin
        push_report(swfr_pkg::VERDICT_ACCEPTED, rr_of(!frame_seq));
        if (byte_count > 0) expected_seq = !expected_seq;
      end else begin
        push_report(swfr_pkg::VERDICT_DUPLICATE, rr_of(!frame_seq));
      end
    end else if (frame_seq != expected_seq) begin
      push_report(swfr_pkg::VERDICT_DUPLICATE, rr_of(expected_seq));
    end else begin
      push_report(swfr_pkg::VERDICT_REJECTED, rej_of(frame_seq));
    end
  endtask

  // One raw line byte through the hunt / destuff state machine
  task automatic deframe_byte(input logic [7:0] b);
    case (hunt)
      swfr_pkg::ST_FLAG: begin
        if (b == cfg.address_byte) hunt = swfr_pkg::ST_ADDR;
        else if (b != cfg.flag_byte) hunt = swfr_pkg::ST_HUNT;
      end
      swfr_pkg::ST_ADDR: begin
        if (b == cfg.control_seq_zero) begin
          frame_seq = 1'b0;
          hunt      = swfr_pkg::ST_CTRL;
        end else if (b == cfg.control_seq_one) begin
          frame_seq = 1'b1;
          hunt      = swfr_pkg::ST_CTRL;
        end else if (b == cfg.flag_byte) begin
          hunt = swfr_pkg::ST_FLAG;
        end else begin
          hunt = swfr_pkg::ST_HUNT;
        end
      end
      swfr_pkg::ST_CTRL: begin
        if (b == (cfg.address_byte ^
                  (frame_seq ? cfg.control_seq_one : cfg.control_seq_zero))) begin
          hunt        = swfr_pkg::ST_DATA;
          held_valid  = 1'b0;
          held_byte   = '0;
          running_xor = '0;
          byte_count  = 0;
        end else begin
          hunt = swfr_pkg::ST_HUNT;
        end
      end
      swfr_pkg::ST_DATA: begin
        if (b == cfg.flag_byte) close_frame();
        else if (b == cfg.escape_byte) hunt = swfr_pkg::ST_ESC;
        else take_data(b);
      end
      swfr_pkg::ST_ESC: begin
        hunt = swfr_pkg::ST_DATA;
        if (b == cfg.escaped_flag_code) take_data(cfg.flag_byte);
        else if (b == cfg.escaped_escape_code) take_data(cfg.escape_byte);
        else push_report(swfr_pkg::VERDICT_BAD_ESC, swfr_pkg::REPLY_NONE);
      end
      default: begin
        hunt = (b == cfg.flag_byte) ? swfr_pkg::ST_FLAG : swfr_pkg::ST_HUNT;
      end
    endcase
  endtask

  // Compare one result beat with the oldest owed result
  task automatic check_result();
    swfr_pkg::res_t got;
    swfr_pkg::res_t want;
    got.kind         = m_tuser;
    got.payload_byte = m_tdata[7:0];
    got.frame_length = m_tdata[18:8];
    got.verdict      = m_tdata[20:19];
    got.reply        = m_tdata[23:21];
    if (got.kind == swfr_pkg::KIND_REPORT) n_report++;
    else n_payload++;
    if (due_results.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: result beat with none owed: kind %0d byte %0h len %0d %s %0d %0d",
                 $realtime, got.kind, got.payload_byte, got.frame_length,
                 "verdict/reply", got.verdict, got.reply);
      return;
    end
    want = due_results.pop_front();
    if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
        got.frame_length !== want.frame_length || got.verdict !== want.verdict ||
        got.reply !== want.reply) begin
      errors++;
      if (errors <= 10) begin
        $display("%0t: mismatch exp kind %0d byte %0h len %0d verdict %0d reply %0d",
                 $realtime, want.kind, want.payload_byte, want.frame_length,
                 want.verdict, want.reply);
        $display("%0t:          act kind %0d byte %0h len %0d verdict %0d reply %0d",
                 $realtime, got.kind, got.payload_byte, got.frame_length,
                 got.verdict, got.reply);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg.flag_byte           = swfr_pkg::FLAG_RST;
      cfg.address_byte        = swfr_pkg::ADDRESS_RST;
      cfg.control_seq_zero    = swfr_pkg::CTRL0_RST;
      cfg.control_seq_one     = swfr_pkg::CTRL1_RST;
      cfg.escape_byte         = swfr_pkg::ESCAPE_RST;
      cfg.escaped_flag_code   = swfr_pkg::ESC_FLAG_RST;
      cfg.escaped_escape_code = swfr_pkg::ESC_ESC_RST;
      hunt         = swfr_pkg::ST_HUNT;
      frame_seq    = 1'b0;
      expected_seq = 1'b0;
      held_valid   = 1'b0;
      held_byte    = '0;
      running_xor  = '0;
      byte_count   = 0;
      due_results.delete();
      errors    = 0;
      n_payload = 0;
      n_report  = 0;
    end else begin
      // register writes land at the access phase
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          swfr_pkg::REG_FLAG:     cfg.flag_byte           = pwdata[7:0];
          swfr_pkg::REG_ADDRESS:  cfg.address_byte        = pwdata[7:0];
          swfr_pkg::REG_CTRL0:    cfg.control_seq_zero    = pwdata[7:0];
          swfr_pkg::REG_CTRL1:    cfg.control_seq_one     = pwdata[7:0];
          swfr_pkg::REG_ESCAPE:   cfg.escape_byte         = pwdata[7:0];
          swfr_pkg::REG_ESC_FLAG: cfg.escaped_flag_code   = pwdata[7:0];
          swfr_pkg::REG_ESC_ESC:  cfg.escaped_escape_code = pwdata[7:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) deframe_byte(s_tdata);
      if (m_tvalid && m_tready) check_result();
    end
    pending = due_results.size();
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// Testbench top: clock, reset, line byte stimulus, register writes and verdict.
module testbench;

  localparam int MAX_LEN        = swfr_pkg::MAX_PAYLOAD_DEF;
  localparam int ITEM_TARGET    = 1900;
  localparam int PHASE_ITEMS    = (ITEM_TARGET - MAX_LEN) / 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 80;
  localparam int SETTLE_CYCLES  = 8;
  localparam int MAX_GAP        = 40;

  // Ways a generated frame can be spoilt
  typedef enum int {
    FAULT_NONE,
    FAULT_CHECK,
    FAULT_ESCAPE,
    FAULT_ADDR,
    FAULT_CTRL,
    FAULT_HDR_SUM,
    FAULT_BARE
  } fault_t;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [7:0]                      s_tdata;    // [7:0] rx_byte
  logic                            m_tvalid;
  logic                            m_tready;
  logic [23:0]                     m_tdata;    // [7:0] payload_byte, [18:8] frame_length,
                                               // [20:19] verdict, [23:21] reply
  logic                            m_tuser;    // [0] kind
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [swfr_pkg::APB_ADDR_W-1:0] paddr;
  logic [swfr_pkg::APB_DATA_W-1:0] pwdata;
  logic [swfr_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  int   errors;
  int   pending;
  int   n_payload;
  int   n_report;

  // Flow-control mix and hold-off requests
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   hold_reqs      = 0;
  int   items_sent     = 0;
  int   stuck_cycles   = 0;
  swfr_pkg::cfg_t cur;

  stop_and_wait_frame_receiver_unit #(.MAX_PAYLOAD(MAX_LEN)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  swfr_result_checker #(.MAX_PAYLOAD(MAX_LEN)) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .errors(errors), .pending(pending), .n_payload(n_payload), .n_report(n_report)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: give up after a long stretch with no beat anywhere
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("stop_and_wait_frame_receiver_unit regression: fail");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Result side: random stalls, plus long hold-offs on request
  initial begin : result_sink
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        m_tready  = 1'b0;
        hold_left = hold_left - 1;
      end else begin
        m_tready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic apb_write(input logic [swfr_pkg::REG_IDX_W-1:0] idx,
                           input logic [7:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {24'd0, val};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Stop sending and let every owed result come out
  task automatic wait_drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_config(input swfr_pkg::cfg_t c);
    wait_drain();
    apb_write(swfr_pkg::REG_FLAG,     c.flag_byte);
    apb_write(swfr_pkg::REG_ADDRESS,  c.address_byte);
    apb_write(swfr_pkg::REG_CTRL0,    c.control_seq_zero);
    apb_write(swfr_pkg::REG_CTRL1,    c.control_seq_one);
    apb_write(swfr_pkg::REG_ESCAPE,   c.escape_byte);
    apb_write(swfr_pkg::REG_ESC_FLAG, c.escaped_flag_code);
    apb_write(swfr_pkg::REG_ESC_ESC,  c.escaped_escape_code);
    cur = c;
  endtask

  // One line byte beat, with a random idle gap in front
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      s_tdata  = 8'($urandom_range(255));
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = b;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Flag and escape bytes go out as escaped pairs
  task automatic send_stuffed(input logic [7:0] d);
    if (d == cur.flag_byte) begin
      send_byte(cur.escape_byte);
      send_byte(cur.escaped_flag_code);
    end else if (d == cur.escape_byte) begin
      send_byte(cur.escape_byte);
      send_byte(cur.escaped_escape_code);
    end else begin
      send_byte(d);
    end
  endtask

  // Payload bytes lean towards the framing codes
  function automatic logic [7:0] line_byte();
    case ($urandom_range(7))
      0:       return cur.flag_byte;
      1:       return cur.escape_byte;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // fill < 0 gives random payload, else every payload byte is fill
  task automatic send_frame(input logic seq, input int n, input fault_t fault,
                            input int fill);
    logic [7:0] ctl;
    logic [7:0] b;
    logic [7:0] chk;
    logic [7:0] code;
    int         bad_at;
    ctl    = seq ? cur.control_seq_one : cur.control_seq_zero;
    chk    = '0;
    bad_at = (fault == FAULT_ESCAPE) ? int'($urandom_range(n, 0)) : -1;
    send_byte(cur.flag_byte);
    send_byte(fault == FAULT_ADDR ? cur.address_byte ^ 8'($urandom_range(255, 1))
                                  : cur.address_byte);
    if (fault == FAULT_CTRL) begin
      do ctl = 8'($urandom_range(255));
      while (ctl == cur.control_seq_zero || ctl == cur.control_seq_one);
    end
    send_byte(ctl);
    send_byte(fault == FAULT_HDR_SUM ? cur.address_byte ^ ctl ^ 8'($urandom_range(255, 1))
                                     : cur.address_byte ^ ctl);
    for (int i = 0; i <= n; i++) begin
      if (i == bad_at) begin
        do code = 8'($urandom_range(255));
        while (code == cur.escaped_flag_code || code == cur.escaped_escape_code);
        send_byte(cur.escape_byte);
        send_byte(code);
      end
      if (i < n) begin
        b   = (fill < 0) ? line_byte() : 8'(fill);
        chk = chk ^ b;
        send_stuffed(b);
      end
    end
    if (fault != FAULT_BARE)
      send_stuffed(fault == FAULT_CHECK ? chk ^ 8'($urandom_range(255, 1)) : chk);
    send_byte(cur.flag_byte);
  endtask

  // Mostly clean frames, some spoilt ones, some line noise
  task automatic random_frame();
    int     pick;
    int     n;
    fault_t fault;
    pick = $urandom_range(99);
    n    = ($urandom_range(7) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 0);
    if (pick < 60)      fault = FAULT_NONE;
    else if (pick < 70) fault = FAULT_CHECK;
    else if (pick < 77) fault = FAULT_ESCAPE;
    else if (pick < 80) fault = FAULT_ADDR;
    else if (pick < 83) fault = FAULT_CTRL;
    else if (pick < 86) fault = FAULT_HDR_SUM;
    else                fault = FAULT_BARE;
    if (pick >= 90) begin
      repeat ($urandom_range(6, 1)) send_byte(line_byte());
    end else begin
      send_frame(1'($urandom_range(1)), n, fault, -1);
    end
  endtask

  initial begin : stimulus
    swfr_pkg::cfg_t setups[4];
    int             phase_start;

    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    cur = '{swfr_pkg::FLAG_RST, swfr_pkg::ADDRESS_RST, swfr_pkg::CTRL0_RST,
            swfr_pkg::CTRL1_RST, swfr_pkg::ESCAPE_RST, swfr_pkg::ESC_FLAG_RST,
            swfr_pkg::ESC_ESC_RST};
    // defaults, low flag / high address, both controls equal, random
    setups[0] = cur;
    setups[1] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h02};
    setups[2] = '{8'hFF, 8'h00, 8'h55, 8'h55, 8'h00, 8'hFF, 8'h00};
    setups[3] = '{8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255))};
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Directed: empty frame, accept with toggle, duplicate, reject, bad escape
    send_frame(1'b0, 0, FAULT_BARE, -1);
    send_frame(1'b0, 2, FAULT_NONE, 8'hFF);
    send_frame(1'b0, 1, FAULT_NONE, 8'h00);
    send_frame(1'b1, 1, FAULT_CHECK, -1);
    send_frame(1'b1, 1, FAULT_ESCAPE, -1);

    // One byte too many: the first MAX_LEN payload bytes go out, then the limit report
    send_frame(1'($urandom_range(1)), MAX_LEN + 1, FAULT_NONE, 8'h11);

    // Long hold-off on the result side while bytes keep coming
    wait_drain();
    hold_reqs = hold_reqs + 1;
    send_frame(1'($urandom_range(1)), 40, FAULT_NONE, -1);
    wait_drain();

    // Random frames over each register setup and flow-control mix
    for (int c = 0; c < 4; c++) begin
      apply_config(setups[c]);
      for (int m = 0; m < 4; m++) begin
        case (m)
          0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1:       begin send_idle_pct = 84; recv_stall_pct = 0;  end
          2:       begin send_idle_pct = 0;  recv_stall_pct = 84; end
          default: begin send_idle_pct = 25; recv_stall_pct = 25; end
        endcase
        phase_start = items_sent;
        while (items_sent - phase_start < PHASE_ITEMS) random_frame();
        wait_drain();
      end
    end

    wait_drain();
    repeat (20) @(negedge clk);
    $display("Covered %0d line bytes over four register setups and four flow-control mixes,",
             items_sent);
    $display("with %0d payload beats and %0d frame reports checked.", n_payload, n_report);
    if (errors == 0 && pending == 0) begin
      $display("stop_and_wait_frame_receiver_unit regression: pass");
    end else begin
      $display("stop_and_wait_frame_receiver_unit regression: fail");
    end
    $finish;
  end

endmodule

/* stop_and_wait_frame_receiver_unit.f */
+incdir+src
src/swfr_pkg.sv
src/swfr_cfg_regs.sv
src/swfr_deframer.sv
src/swfr_out_reg.sv
src/stop_and_wait_frame_receiver_unit.sv
verif/swfr_result_checker.sv
verif/testbench.sv
